// ----- hdl/assert_macros.svh -----
// assertion macros shared by the modexp block
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ----- hdl/mes_pkg.sv -----
// shared types and constants of the modular exponentiation stream
// no dependencies; used by every other file of the block but assert_macros.svh and mes_modmul
package mes_pkg;

  localparam int DATA_W     = 32;
  localparam int APB_ADDR_W = 3;

  // register index, taken from paddr[2]
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  localparam logic [DATA_W-1:0] EXPONENT_RESET = 32'd0;
  localparam logic [DATA_W-1:0] MODULUS_RESET  = 32'd1;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_REDUCE  = 6'b000010,
    ST_CHECK   = 6'b000100,
    ST_MUL_ACC = 6'b001000,
    ST_MUL_SQ  = 6'b010000,
    ST_DONE    = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;
    logic start_reduce;
    logic start_acc;
    logic start_sq;
    logic store_acc;
    logic store_sq;
    logic shift_ex;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic ex_zero;
    logic ex_lsb;
    logic mod_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/mes_stream_if.sv -----
// valid/ready stream interfaces for message values in and results out
// depends on mes_pkg
interface mes_in_if;
  logic                        valid;
  logic                        ready;
  logic [mes_pkg::DATA_W-1:0]  message_value;
  logic                        last_in;

  modport source (output valid, output message_value, output last_in, input ready);
  modport sink   (input valid, input message_value, input last_in, output ready);
endinterface

interface mes_out_if;
  logic                        valid;
  logic                        ready;
  logic [mes_pkg::DATA_W-1:0]  result_value;
  logic                        last_out;

  modport source (output valid, output result_value, output last_out, input ready);
  modport sink   (input valid, input result_value, input last_out, output ready);
endinterface

// ----- hdl/mes_apb_regs.sv -----
// apb register file: exponent and modulus
// depends on mes_pkg
module mes_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mes_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mes_pkg::DATA_W-1:0]     pwdata,
  output logic [mes_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output logic [mes_pkg::DATA_W-1:0]     exponent,
  output logic [mes_pkg::DATA_W-1:0]     modulus
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= mes_pkg::EXPONENT_RESET;
      modulus  <= mes_pkg::MODULUS_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        mes_pkg::REG_EXPONENT: exponent <= pwdata;
        mes_pkg::REG_MODULUS:  modulus  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mes_pkg::REG_EXPONENT: prdata = exponent;
      mes_pkg::REG_MODULUS:  prdata = modulus;
      default:               prdata = '0;
    endcase
  end

endmodule

// ----- hdl/mes_modmul.sv -----
// bit-serial modular multiplier, one multiplier bit per cycle
// depends on assert_macros.svh; operands must be below the modulus
`include "assert_macros.svh"

module mes_modmul #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] m,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] result
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W + 1);
  localparam int TW = W + 2;

  logic [W-1:0]  a_r;
  logic [W-1:0]  m_r;
  logic [W-1:0]  b_sh;
  logic [W-1:0]  acc;
  logic [W-1:0]  acc_next;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [TW-1:0] t;
  logic [TW-1:0] m1;
  logic [TW-1:0] m2;

  // acc < m and a < m, so 2*acc + a < 3m: at most two subtractions of m
  always_comb begin
    t  = TW'({acc, 1'b0}) + (b_sh[W-1] ? TW'(a_r) : '0);
    m1 = TW'(m_r);
    m2 = TW'({m_r, 1'b0});
    if (t >= m2) begin
      acc_next = W'(t - m2);
    end else if (t >= m1) begin
      acc_next = W'(t - m1);
    end else begin
      acc_next = W'(t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      m_r  <= m;
      b_sh <= b;
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= b_sh << 1;
    end
  end

  assign result = acc;

  `ASSERT_ALWAYS(a_acc_reduced, clk, rst, busy |-> (acc < m_r), "modmul accumulator left range")
  `ASSERT_NEVER(a_start_busy, clk, rst, start && busy, "modmul started while running")
  `ASSERT_ALWAYS(a_done_end, clk, rst, done |-> ($past(busy) && !busy), "modmul done without run")

endmodule

// ----- hdl/mes_dp.sv -----
// datapath: exponent shifter, running power and result registers, output beat
// depends on mes_pkg and mes_modmul
module mes_dp #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mes_pkg::DATA_W-1:0]  exponent,
  input  logic [mes_pkg::DATA_W-1:0]  modulus,
  input  logic [mes_pkg::DATA_W-1:0]  message_value,
  input  logic                        last_in,
  input  mes_pkg::dp_cmd_t            cmd,
  output mes_pkg::dp_status_t         status,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [mes_pkg::DATA_W-1:0]  result_value,
  output logic                        last_out
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = mes_pkg::DATA_W;

  logic [W-1:0] m_w;
  logic [W-1:0] one_m;
  logic [W-1:0] acc;
  logic [W-1:0] sq;
  logic [W-1:0] ex;
  logic         last_r;
  logic         mul_start;
  logic [W-1:0] mul_a;
  logic [W-1:0] mul_b;
  logic         mul_done;
  logic [W-1:0] mul_res;

  assign m_w   = W'(modulus);
  assign one_m = (m_w > W'(1)) ? W'(1) : '0;

  // reduction of the base is a multiply by 1 mod m
  assign mul_start = cmd.start_reduce || cmd.start_acc || cmd.start_sq;
  assign mul_a     = cmd.start_reduce ? one_m : (cmd.start_acc ? acc : sq);
  assign mul_b     = cmd.start_reduce ? W'(message_value) : sq;

  mes_modmul #(
    .OPERAND_WIDTH (W)
  ) u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (m_w),
    .done   (mul_done),
    .result (mul_res)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc    <= one_m;
      ex     <= W'(exponent);
      last_r <= last_in;
    end else begin
      if (cmd.store_acc) begin
        acc <= mul_res;
      end
      if (cmd.shift_ex) begin
        ex <= ex >> 1;
      end
    end
    if (cmd.store_sq) begin
      sq <= mul_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_value <= DW'(acc);
      last_out     <= last_r;
    end
  end

  always_comb begin
    status.mul_done = mul_done;
    status.ex_zero  = (ex == '0);
    status.ex_lsb   = ex[0];
    status.mod_zero = (m_w == '0);
    status.out_free = !out_valid || out_ready;
  end

endmodule

// ----- hdl/mes_ctrl.sv -----
// controller: sequences reduction, square and multiply steps per item
// depends on mes_pkg and assert_macros.svh
`include "assert_macros.svh"

module mes_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mes_pkg::dp_status_t  status,
  output mes_pkg::dp_cmd_t     cmd
);

  mes_pkg::state_t state;
  mes_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == mes_pkg::ST_IDLE);
    case (state)
      mes_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          // zero modulus: result stays 0, no arithmetic
          if (status.mod_zero) begin
            state_next = mes_pkg::ST_DONE;
          end else begin
            cmd.start_reduce = 1'b1;
            state_next       = mes_pkg::ST_REDUCE;
          end
        end
      end
      mes_pkg::ST_REDUCE: begin
        if (status.mul_done) begin
          cmd.store_sq = 1'b1;
          state_next   = mes_pkg::ST_CHECK;
        end
      end
      mes_pkg::ST_CHECK: begin
        if (status.ex_zero) begin
          state_next = mes_pkg::ST_DONE;
        end else if (status.ex_lsb) begin
          cmd.start_acc = 1'b1;
          state_next    = mes_pkg::ST_MUL_ACC;
        end else begin
          cmd.start_sq = 1'b1;
          state_next   = mes_pkg::ST_MUL_SQ;
        end
      end
      mes_pkg::ST_MUL_ACC: begin
        if (status.mul_done) begin
          cmd.store_acc = 1'b1;
          cmd.start_sq  = 1'b1;
          state_next    = mes_pkg::ST_MUL_SQ;
        end
      end
      mes_pkg::ST_MUL_SQ: begin
        if (status.mul_done) begin
          cmd.store_sq = 1'b1;
          cmd.shift_ex = 1'b1;
          state_next   = mes_pkg::ST_CHECK;
        end
      end
      mes_pkg::ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mes_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_ALWAYS(a_single_start, clk, rst, $countones({cmd.start_reduce, cmd.start_acc, cmd.start_sq}) <= 1, "two multiplies started at once")
  `ASSERT_ALWAYS(a_step_needs_bits, clk, rst, (cmd.start_acc || cmd.start_sq) |-> !status.ex_zero, "exponent step with no bits left")

endmodule

// ----- hdl/modular_exponentiation_stream.sv -----
// modular exponentiation stream: result = message_value ^ exponent mod modulus
// steps per item: reduce the base, then for each exponent bit up to the highest set one a square,
//   preceded by a multiply into the result when that bit is set
// one item at a time, set by the single bit-serial modular multiplier; the output register
//   frees the input early
// synchronous active-high reset: exponent 0, modulus 1, no result pending
module modular_exponentiation_stream #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mes_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mes_pkg::DATA_W-1:0]     pwdata,
  output logic [mes_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  mes_in_if.sink                         msg_in,
  mes_out_if.source                      res_out
);

  logic [mes_pkg::DATA_W-1:0] exponent;
  logic [mes_pkg::DATA_W-1:0] modulus;
  mes_pkg::dp_cmd_t           cmd;
  mes_pkg::dp_status_t        status;
  logic                       in_ready;

  mes_apb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .exponent (exponent),
    .modulus  (modulus)
  );

  mes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (msg_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  assign msg_in.ready = in_ready;

  mes_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .exponent      (exponent),
    .modulus       (modulus),
    .message_value (msg_in.message_value),
    .last_in       (msg_in.last_in),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (res_out.ready),
    .out_valid     (res_out.valid),
    .result_value  (res_out.result_value),
    .last_out      (res_out.last_out)
  );

endmodule
